### design/edfgof_pkg.sv
// Shared constants, command and status types for the EDF goodness-of-fit block.
package edfgof_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = FRAC_BITS + 1;       // Q1.FRAC_BITS input values
  localparam int SQ_W      = 2 * FRAC_BITS + 1;   // |E-F|^2 never exceeds ONE^2
  localparam int DEN_W     = 2 * FRAC_BITS - 1;   // F*(ONE-F) never exceeds ONE^2/4
  localparam int NUM_W     = 3 * FRAC_BITS + 1;   // |E-F|^2*|dF| never exceeds ONE^3
  localparam int ACC_W     = NUM_W + 2;           // signed accumulator headroom
  localparam int STAT_W    = 32;
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int SEL_W     = 2;

  localparam logic [IN_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic signed [ACC_W-1:0] SUM_MAX =
    {{(ACC_W - STAT_W + 1){1'b0}}, {(STAT_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SUM_MIN =
    {{(ACC_W - STAT_W + 1){1'b1}}, {(STAT_W - 1){1'b0}}};

  // statistic_select codes
  localparam logic [SEL_W-1:0] SEL_KS     = 2'd0;
  localparam logic [SEL_W-1:0] SEL_CVM    = 2'd1;
  localparam logic [SEL_W-1:0] SEL_AD     = 2'd2;
  localparam logic [SEL_W-1:0] SEL_KS_ALT = 2'd3;

  typedef struct packed {
    logic load;       // capture a point
    logic mul_a;      // square the difference, form the AD weight
    logic mul_b;      // multiply by |dF|, clear the remainder
    logic div_step;   // one restoring division step
    logic acc;        // add the term into the running sum
    logic emit;       // move the statistic to the output register
  } edfgof_cmd_t;

  typedef struct packed {
    logic [SEL_W-1:0] mode;
    logic             den_zero;
    logic             last;
    logic             out_free;
  } edfgof_sts_t;

endpackage

### design/edfgof_datapath.sv
// Datapath: clamping, multipliers, restoring divider, accumulator, output register.
module edfgof_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          statistic_select_we_i,
  input  logic [edfgof_pkg::SEL_W-1:0]  statistic_select_i,
  input  logic [edfgof_pkg::IN_W-1:0]   edf_value_i,
  input  logic [edfgof_pkg::IN_W-1:0]   model_value_i,
  input  logic                          last_point_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic signed [edfgof_pkg::STAT_W-1:0] statistic_o,
  output logic                          saturated_o,
  input  edfgof_pkg::edfgof_cmd_t       cmd_i,
  output edfgof_pkg::edfgof_sts_t       sts_o
);
  import edfgof_pkg::*;

  logic [SEL_W-1:0]  sel_q;
  logic [SEL_W-1:0]  mode_q;
  logic              last_q;
  logic [IN_W-1:0]   prev_q;
  logic [IN_W-1:0]   max_q;
  logic signed [STAT_W-1:0] sum_q;
  logic              ovf_q;
  logic              out_valid_q;
  logic signed [STAT_W-1:0] stat_q;
  logic              sat_q;

  logic [IN_W-1:0]   ad_q, dfm_q, f_q;
  logic              dfneg_q;
  logic [SQ_W-1:0]   sq_q;
  logic [DEN_W-1:0]  den_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  rem_q;

  logic [IN_W-1:0]   e_c, f_c, ad_d, dfm_d;
  logic              dfneg_d;
  logic [2*IN_W-1:0] sq_full, den_full;
  logic [SQ_W+IN_W-1:0] num_full;
  logic [DEN_W:0]    rem_sh;
  logic              q_bit;
  logic [DEN_W-1:0]  rem_d;
  logic [NUM_W-1:0]  mag;
  logic signed [ACC_W-1:0] sum_ext, mag_ext, acc_sum;
  logic              use_term;
  logic              sum_mode;

  // Clamp inputs to one, form |E-F| and |dF|.
  always_comb begin
    e_c     = (edf_value_i > ONE) ? ONE : edf_value_i;
    f_c     = (model_value_i > ONE) ? ONE : model_value_i;
    ad_d    = (e_c >= f_c) ? (e_c - f_c) : (f_c - e_c);
    dfneg_d = f_c < prev_q;
    dfm_d   = dfneg_d ? (prev_q - f_c) : (f_c - prev_q);
  end

  assign sq_full  = ad_q * ad_q;
  assign den_full = f_q * (ONE - f_q);
  assign num_full = sq_q * dfm_q;

  // Restoring division: one quotient bit per step, quotient shifts into num_q.
  always_comb begin
    rem_sh = {rem_q, num_q[NUM_W-1]};
    q_bit  = rem_sh >= {1'b0, den_q};
    rem_d  = q_bit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
  end

  assign sum_mode = (mode_q == SEL_CVM) || (mode_q == SEL_AD);

  always_comb begin
    mag      = (mode_q == SEL_CVM) ? (num_q >> (2 * FRAC_BITS)) : num_q;
    use_term = (mode_q == SEL_CVM) || ((mode_q == SEL_AD) && (den_q != '0));
    sum_ext  = {{(ACC_W - STAT_W){sum_q[STAT_W-1]}}, sum_q};
    mag_ext  = $signed({2'b00, mag});
    acc_sum  = dfneg_q ? (sum_ext - mag_ext) : (sum_ext + mag_ext);
  end

  // Control and run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= SEL_KS;
      prev_q      <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (statistic_select_we_i) begin
        sel_q <= statistic_select_i;
      end
      if (cmd_i.load) begin
        prev_q <= f_c;
        if (ad_d > max_q) begin
          max_q <= ad_d;
        end
      end
      if (cmd_i.acc && use_term) begin
        if (acc_sum > SUM_MAX) begin
          sum_q <= SUM_MAX[STAT_W-1:0];
          ovf_q <= 1'b1;
        end else if (acc_sum < SUM_MIN) begin
          sum_q <= SUM_MIN[STAT_W-1:0];
          ovf_q <= 1'b1;
        end else begin
          sum_q <= acc_sum[STAT_W-1:0];
        end
      end
      if (cmd_i.emit) begin
        prev_q      <= '0;
        max_q       <= '0;
        sum_q       <= '0;
        ovf_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ad_q    <= ad_d;
      dfm_q   <= dfm_d;
      dfneg_q <= dfneg_d;
      f_q     <= f_c;
      last_q  <= last_point_i;
      mode_q  <= sel_q;
    end
    if (cmd_i.mul_a) begin
      sq_q  <= sq_full[SQ_W-1:0];
      den_q <= den_full[DEN_W-1:0];
    end
    if (cmd_i.mul_b) begin
      num_q <= num_full[NUM_W-1:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NUM_W-2:0], q_bit};
      rem_q <= rem_d;
    end
    if (cmd_i.emit) begin
      stat_q <= sum_mode ? sum_q : $signed({{(STAT_W - IN_W){1'b0}}, max_q});
      sat_q  <= ovf_q;
    end
  end

  assign sts_o.mode     = mode_q;
  assign sts_o.den_zero = (den_q == '0);
  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign statistic_o = stat_q;
  assign saturated_o = sat_q;

`ifndef SYNTHESIS
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (out_valid_q && sum_q == '0 && max_q == '0 && !ovf_q))
    else $error("run state not cleared after emit");
  a_ks_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.acc && (mode_q == SEL_KS || mode_q == SEL_KS_ALT)) |=> $stable(sum_q))
    else $error("running sum moved on a KS point");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("emit overwrote a pending result");
`endif

endmodule

### design/edfgof_ctrl.sv
// Controller: sequences one point through multiply, divide, accumulate and emit.
module edfgof_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output edfgof_pkg::edfgof_cmd_t cmd_o,
  input  edfgof_pkg::edfgof_sts_t sts_i
);
  import edfgof_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: begin
        cnt_d = '0;
        // Only a nonzero AD weight needs the divider.
        if (sts_i.mode == SEL_AD && !sts_i.den_zero) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_ACC;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: state_d = sts_i.last ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul_a    = (state_q == ST_MUL_A);
    cmd_o.mul_b    = (state_q == ST_MUL_B);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.acc      = (state_q == ST_ACC);
    cmd_o.emit     = (state_q == ST_EMIT) && sts_i.out_free;
  end

  assign in_stall_o = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_MUL_A)
    else $error("accepted point did not start the multiply");
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |=> (state_q == ST_DIV || state_q == ST_ACC))
    else $error("divider left early");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q <= CNT_W'(NUM_W - 1))
    else $error("division step count overrun");
`endif

endmodule

### design/edf_goodness_of_fit_statistic.sv
// Top level of the EDF goodness-of-fit statistic block.
//
//  channel   direction  handshake                      payload
//  -------   ---------  -----------------------------  ---------------------------------
//  point     in         in_valid_i / in_stall_o         edf_value_i, model_value_i,
//                                                       last_point_i
//  result    out        out_valid_o / out_stall_i       statistic_o, saturated_o
//  config    in         statistic_select_we_i           statistic_select_i
//
// One point is worked at a time: accept, square, multiply, accumulate. An AD
// point with a nonzero weight adds 49 restoring-divider steps (one quotient bit
// per cycle) before the accumulate.
// A last point adds an emit state, held while a previous result is stalled.
// The result register frees the input side: a new run starts while a result waits.
// Reset clears the selector to KS and the run state to zero.
module edf_goodness_of_fit_statistic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 statistic_select_we_i,
  input  logic [edfgof_pkg::SEL_W-1:0]         statistic_select_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [edfgof_pkg::IN_W-1:0]          edf_value_i,
  input  logic [edfgof_pkg::IN_W-1:0]          model_value_i,
  input  logic                                 last_point_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [edfgof_pkg::STAT_W-1:0] statistic_o,
  output logic                                 saturated_o
);
  import edfgof_pkg::*;

  // Commands flow down from the controller, status flows back up.
  edfgof_cmd_t cmd;
  edfgof_sts_t sts;

  edfgof_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Hold the selector, run state and result register in the datapath.
  edfgof_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .statistic_select_we_i (statistic_select_we_i),
    .statistic_select_i    (statistic_select_i),
    .edf_value_i           (edf_value_i),
    .model_value_i         (model_value_i),
    .last_point_i          (last_point_i),
    .out_stall_i           (out_stall_i),
    .out_valid_o           (out_valid_o),
    .statistic_o           (statistic_o),
    .saturated_o           (saturated_o),
    .cmd_i                 (cmd),
    .sts_o                 (sts)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for the EDF goodness-of-fit statistic block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import edfgof_pkg::*;

  localparam int     SETTLE_CYCLES = 80;        // longest AD point plus emit, with margin
  localparam int     CYCLE_LIMIT   = 1_000_000;
  localparam longint STAT_HI       = 64'sd2147483647;
  localparam longint STAT_LO       = -64'sd2147483648;

  localparam logic [SEL_W-1:0] SELECT_ORDER [4] = '{SEL_KS, SEL_CVM, SEL_AD, SEL_KS_ALT};

  typedef struct {
    logic [IN_W-1:0] edf;
    logic [IN_W-1:0] model;
    logic            last;
  } gof_point_t;

  typedef struct {
    logic signed [STAT_W-1:0] statistic;
    logic                     saturated;
  } gof_result_t;

  // Block ports; every input starts at a known value.
  logic                     clk_i                 = 1'b0;
  logic                     rst_ni                = 1'b0;
  logic                     statistic_select_we_i = 1'b0;
  logic [SEL_W-1:0]         statistic_select_i    = SEL_KS;
  logic                     in_valid_i            = 1'b0;
  logic                     in_stall_o;
  logic [IN_W-1:0]          edf_value_i           = '0;
  logic [IN_W-1:0]          model_value_i         = '0;
  logic                     last_point_i          = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i           = 1'b0;
  logic signed [STAT_W-1:0] statistic_o;
  logic                     saturated_o;

  // Points waiting to be driven, and statistics waiting to come out.
  gof_point_t  pending_points[$];
  gof_result_t expected_stats[$];

  // Shadow of the block's run state and selector.
  logic [SEL_W-1:0] select_shadow = SEL_KS;
  logic [IN_W-1:0]  prev_model    = '0;
  longint           run_sum       = 0;
  logic [IN_W-1:0]  run_max       = '0;
  logic             run_sat       = 1'b0;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int stall_style    = 0;

  edf_goodness_of_fit_statistic DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .statistic_select_we_i (statistic_select_we_i),
    .statistic_select_i    (statistic_select_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .edf_value_i           (edf_value_i),
    .model_value_i         (model_value_i),
    .last_point_i          (last_point_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .statistic_o           (statistic_o),
    .saturated_o           (saturated_o)
  );

  always #10 clk_i = ~clk_i;

  // Clamp an integer level into [0, ONE].
  function automatic int level_of(input int v);
    if (v < 0) return 0;
    if (v > int'(ONE)) return int'(ONE);
    return v;
  endfunction

  // Pick from the corners of the field, over-one codes included.
  function automatic logic [IN_W-1:0] corner_level();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return IN_W'(1);
      2:       return IN_W'(2);
      3:       return ONE - IN_W'(2);
      4:       return ONE - IN_W'(1);
      5:       return ONE;
      default: return IN_W'($urandom_range(int'(ONE) + 1, (1 << IN_W) - 1));
    endcase
  endfunction

  // Fold one accepted point into the shadow state; queue the statistic at a last point.
  task automatic fold_point(input logic [IN_W-1:0] e_raw, input logic [IN_W-1:0] f_raw,
                            input logic last);
    logic [IN_W-1:0] e, f;
    longint unsigned diff, dfm, num, den, mag;
    logic            df_neg, use_term;
    longint          acc;
    gof_result_t     res;
    // Levels above one count as one.
    e = (e_raw > ONE) ? ONE : e_raw;
    f = (f_raw > ONE) ? ONE : f_raw;
    diff   = (e >= f) ? longint'(e) - longint'(f) : longint'(f) - longint'(e);
    df_neg = f < prev_model;
    dfm    = df_neg ? longint'(prev_model) - longint'(f) : longint'(f) - longint'(prev_model);
    // The KS max is tracked whatever the mode.
    if (diff > run_max) run_max = diff[IN_W-1:0];
    if (select_shadow == SEL_CVM || select_shadow == SEL_AD) begin
      num      = diff * diff * dfm;
      use_term = 1'b1;
      if (select_shadow == SEL_CVM) begin
        den = longint'(1) << (2 * FRAC_BITS);
      end else begin
        // Zero weight at F of zero or one: drop the term.
        den = longint'(f) * (longint'(ONE) - longint'(f));
        if (den == 0) use_term = 1'b0;
      end
      if (use_term) begin
        mag = num / den;
        acc = df_neg ? run_sum - longint'(mag) : run_sum + longint'(mag);
        if (acc > STAT_HI) begin
          acc     = STAT_HI;
          run_sat = 1'b1;
        end else if (acc < STAT_LO) begin
          acc     = STAT_LO;
          run_sat = 1'b1;
        end
        run_sum = acc;
      end
    end
    prev_model = f;
    if (last) begin
      // Report by the mode in force at the last point, then clear the run.
      if (select_shadow == SEL_CVM || select_shadow == SEL_AD)
        res.statistic = run_sum[STAT_W-1:0];
      else
        res.statistic = STAT_W'(run_max);
      res.saturated = run_sat;
      expected_stats.push_back(res);
      prev_model = '0;
      run_sum    = 0;
      run_max    = '0;
      run_sat    = 1'b0;
    end
  endtask

  task automatic push_point(input logic [IN_W-1:0] e, input logic [IN_W-1:0] f,
                            input logic last);
    gof_point_t p;
    p.edf   = e;
    p.model = f;
    p.last  = last;
    pending_points.push_back(p);
  endtask

  // Queue one run of points; an open run has no last flag and may span a mode change.
  task automatic queue_run(input int len, input bit closed);
    int         f, e, spread, style;
    gof_point_t p;
    style  = $urandom_range(0, 9);
    f      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 4000);
    spread = $urandom_range(0, 24000);
    for (int i = 0; i < len; i++) begin
      if (style <= 4) begin
        // Well-formed: F climbs, E wanders around it; sometimes jump near one.
        f = level_of(f + $urandom_range(0, 2 * 65536 / len));
        if ($urandom_range(0, 15) == 0) f = int'(ONE) - $urandom_range(0, 2);
        e = f + int'($urandom_range(0, 2 * spread)) - spread;
        p.model = IN_W'(f);
        p.edf   = IN_W'(level_of(e));
      end else if (style <= 6) begin
        p.model = IN_W'($urandom_range(0, int'(ONE)));
        p.edf   = IN_W'($urandom_range(0, int'(ONE)));
      end else if (style <= 8) begin
        p.model = corner_level();
        p.edf   = corner_level();
      end else begin
        // Raw noise over the whole field, over-one codes included.
        p.model = IN_W'($urandom_range(0, (1 << IN_W) - 1));
        p.edf   = IN_W'($urandom_range(0, (1 << IN_W) - 1));
      end
      p.last = closed && (i == len - 1);
      pending_points.push_back(p);
    end
  endtask

  // Wait for all points to drain and all statistics to arrive, then let the block go quiet.
  task automatic settle();
    do @(posedge clk_i);
    while (pending_points.size() != 0 || in_valid_i || expected_stats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_select(input logic [SEL_W-1:0] code);
    settle();
    statistic_select_we_i <= 1'b1;
    statistic_select_i    <= code;
    @(posedge clk_i);
    statistic_select_we_i <= 1'b0;
    select_shadow = code;
  endtask

  // Point driver: bursts of random length, random gaps; hold while stalled.
  always @(posedge clk_i or negedge rst_ni) begin : point_driver
    gof_point_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_points.size() > 0) begin
        nxt = pending_points.pop_front();
        in_valid_i    <= 1'b1;
        edf_value_i   <= nxt.edf;
        model_value_i <= nxt.model;
        last_point_i  <= nxt.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result stall: segments of no stall, random stall, or long periodic stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 2);
        stall_left  = $urandom_range(16, 96);
      end
      stall_left--;
      case (stall_style)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= (stall_left % 12) < 7;
      endcase
    end
  end

  // Monitor: check each result transaction first, then fold in any accepted point.
  always @(posedge clk_i) begin : stat_monitor
    gof_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_stats.size() == 0) begin
          $error("statistic: none expected, got %0d", statistic_o);
          mismatch_count++;
        end else begin
          want = expected_stats.pop_front();
          if (statistic_o !== want.statistic) begin
            $error("statistic: expected %0d, got %0d", want.statistic, statistic_o);
            mismatch_count++;
          end
          if (saturated_o !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, saturated_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        fold_point(edf_value_i, model_value_i, last_point_i);
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int budget, len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // KS after reset: full-scale distance both ways, over-one code clamps.
    push_point('0, ONE, 1'b1);
    push_point('1, '0, 1'b1);

    // CvM: a rising step and a falling step cancel.
    write_select(SEL_CVM);
    push_point('0, ONE, 1'b0);
    push_point(ONE, '0, 1'b1);

    // AD: zero weight at F of one, negative then positive saturation,
    // zero weight at F of zero, clamped inputs, then leave the run open.
    write_select(SEL_AD);
    push_point(ONE, ONE, 1'b0);
    push_point(ONE, IN_W'(1), 1'b0);
    push_point('0, '0, 1'b1);
    push_point('0, ONE - IN_W'(1), 1'b1);
    push_point('1, '1, 1'b0);
    push_point(IN_W'(100), IN_W'(30000), 1'b0);

    // Selector three finishes the open run as a KS max.
    write_select(SEL_KS_ALT);
    push_point(IN_W'(40000), IN_W'(30001), 1'b1);

    // Saturate in AD, then close the run in KS: flag still reported.
    write_select(SEL_AD);
    push_point('0, '0, 1'b0);
    push_point('0, ONE - IN_W'(1), 1'b0);
    write_select(SEL_KS);
    push_point(ONE, ONE, 1'b1);

    // Random phases, each under its own selector; runs may stay open across a change.
    for (int ph = 0; ph < 8; ph++) begin
      write_select(ph < 4 ? SELECT_ORDER[2'(ph)] : SELECT_ORDER[2'($urandom_range(0, 3))]);
      budget = 200;
      while (budget > 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if (len > budget) len = budget;
        budget -= len;
        queue_run(len, budget > 0 || $urandom_range(0, 2) != 0);
      end
    end

    settle();
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
design/edfgof_pkg.sv
design/edfgof_datapath.sv
design/edfgof_ctrl.sv
design/edf_goodness_of_fit_statistic.sv
tb/testbench.sv
